[hw/rtl/lrf_pkg.sv]
// lrf_pkg: shared types, codes and character constants for the display formatter
package lrf_pkg;

  localparam logic [1:0] CMD_INIT    = 2'd0;
  localparam logic [1:0] CMD_CLIMATE = 2'd1;
  localparam logic [1:0] CMD_LIGHT   = 2'd2;

  localparam int LRF_QUEUE_DEPTH = 2;
  localparam int NUM_DIGITS      = 7;

  localparam logic [7:0] LCD_FUNCTION_SET = 8'h38;
  localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] LCD_CLEAR        = 8'h01;
  localparam logic [7:0] LCD_HOME         = 8'h80;
  localparam logic [7:0] CHR_ZERO         = 8'd48;
  localparam logic [7:0] CHR_PERCENT      = 8'h25;
  localparam logic [7:0] CHR_SPACE        = 8'h20;
  localparam logic [7:0] CHR_POINT        = 8'h2E;
  localparam logic [7:0] CHR_DEGREE       = 8'hEB;
  localparam logic [7:0] CHR_UPPER_C      = 8'h43;
  localparam logic [7:0] CHR_UPPER_L      = 8'h4C;
  localparam logic [7:0] CHR_LOWER_X      = 8'h78;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic [1:0]                   cmd;
    logic [NUM_DIGITS-1:0][3:0]   dig;
  } lrf_job_t;

  function automatic logic [7:0] ascii_digit(input digit_t d);
    ascii_digit = CHR_ZERO + {4'd0, d};
  endfunction

  function automatic logic [3:0] run_last_idx(input logic [1:0] cmd);
    case (cmd)
      CMD_INIT:    run_last_idx = 4'd4;
      CMD_CLIMATE: run_last_idx = 4'd11;
      default:     run_last_idx = 4'd6;
    endcase
  endfunction

endpackage

[hw/rtl/lrf_front.sv]
// lrf_front: accepts requests, converts readings to decimal digits, builds jobs
module lrf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic [7:0]        in_humidity,
  input  logic [7:0]        in_temp_whole,
  input  logic [7:0]        in_temp_fraction,
  input  logic [15:0]       in_light_level,
  output logic              job_valid,
  input  logic              job_ready,
  output lrf_pkg::lrf_job_t job
);
  import lrf_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [15:0] shreg_r, shreg_nxt;
  logic [19:0] bcd_r, bcd_nxt;

  logic        accept;
  logic [7:0]  hum_sat, tmp_sat;
  logic [6:0]  frac_rem;
  logic [1:0]  frac_hund;
  digit_t      hum_t, hum_o, tmp_t, tmp_o, frac_t, frac_o;
  lrf_job_t    direct_job, light_job;

  function automatic logic [19:0] dd_step(input logic [19:0] b, input logic bit_in);
    logic [19:0] adj;
    for (int k = 0; k < 5; k++) begin
      adj[k*4 +: 4] = (b[k*4 +: 4] >= 4'd5) ? b[k*4 +: 4] + 4'd3 : b[k*4 +: 4];
    end
    dd_step = {adj[18:0], bit_in};
  endfunction

  function automatic logic [3:0] tens_of(input logic [6:0] x);
    logic [14:0] prod;
    prod    = {8'd0, x} * 15'd205;
    tens_of = prod[14:11];
  endfunction

  function automatic logic [3:0] ones_of(input logic [6:0] x, input logic [3:0] t);
    logic [6:0] tx10;
    tx10    = {t, 3'd0} + {2'd0, t, 1'b0};
    ones_of = 4'(x - tx10);
  endfunction

  assign in_ready = !busy_r && !done_r && job_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    hum_sat   = (in_humidity   > 8'd99) ? 8'd99 : in_humidity;
    tmp_sat   = (in_temp_whole > 8'd99) ? 8'd99 : in_temp_whole;
    hum_t     = tens_of(hum_sat[6:0]);
    hum_o     = ones_of(hum_sat[6:0], hum_t);
    tmp_t     = tens_of(tmp_sat[6:0]);
    tmp_o     = ones_of(tmp_sat[6:0], tmp_t);
    if (in_temp_fraction >= 8'd200) begin
      frac_hund = 2'd2;
      frac_rem  = 7'(in_temp_fraction - 8'd200);
    end else if (in_temp_fraction >= 8'd100) begin
      frac_hund = 2'd1;
      frac_rem  = 7'(in_temp_fraction - 8'd100);
    end else begin
      frac_hund = 2'd0;
      frac_rem  = in_temp_fraction[6:0];
    end
    frac_t    = tens_of(frac_rem);
    frac_o    = ones_of(frac_rem, frac_t);

    direct_job.cmd    = in_command;
    direct_job.dig[0] = hum_t;
    direct_job.dig[1] = hum_o;
    direct_job.dig[2] = tmp_t;
    direct_job.dig[3] = tmp_o;
    direct_job.dig[4] = {2'd0, frac_hund};
    direct_job.dig[5] = frac_t;
    direct_job.dig[6] = frac_o;

    light_job.cmd    = CMD_LIGHT;
    light_job.dig[0] = bcd_r[19:16];
    light_job.dig[1] = bcd_r[15:12];
    light_job.dig[2] = bcd_r[11:8];
    light_job.dig[3] = bcd_r[7:4];
    light_job.dig[4] = bcd_r[3:0];
    light_job.dig[5] = 4'd0;
    light_job.dig[6] = 4'd0;
  end

  assign job_valid = done_r ||
                     (accept && (in_command == CMD_INIT || in_command == CMD_CLIMATE));
  assign job       = done_r ? light_job : direct_job;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = done_r;
    cnt_nxt   = cnt_r;
    shreg_nxt = shreg_r;
    bcd_nxt   = bcd_r;
    if (accept && in_command == CMD_LIGHT) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = 3'd0;
      shreg_nxt = in_light_level;
      bcd_nxt   = 20'd0;
    end else if (busy_r) begin
      bcd_nxt   = dd_step(dd_step(bcd_r, shreg_r[15]), shreg_r[14]);
      shreg_nxt = {shreg_r[13:0], 2'b00};
      cnt_nxt   = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (done_r && job_ready) begin
      done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    shreg_r <= shreg_nxt;
    bcd_r   <= bcd_nxt;
  end

endmodule

[hw/rtl/lrf_queue.sv]
// lrf_queue: small job fifo between the front and the back
module lrf_queue #(
  parameter int DEPTH = lrf_pkg::LRF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  lrf_pkg::lrf_job_t push_job,
  output logic              pop_valid,
  input  logic              pop_ready,
  output lrf_pkg::lrf_job_t pop_job
);
  import lrf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lrf_job_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[hw/rtl/lrf_back.sv]
// lrf_back: walks one job at a time and emits its display writes
module lrf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  lrf_pkg::lrf_job_t job,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_register_select,
  output logic [7:0]        out_lcd_byte,
  output logic              out_last
);
  import lrf_pkg::*;

  lrf_job_t    cur_r, cur_nxt;
  logic        active_r, active_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        rs_r, last_r;
  logic [7:0]  byte_r;

  logic        emit, at_last;
  logic [7:0]  cur_byte;

  assign emit      = active_r && (!out_valid_r || out_ready);
  assign at_last   = (idx_r == run_last_idx(cur_r.cmd));
  assign job_ready = !active_r || (emit && at_last);

  always_comb begin
    cur_byte = CHR_LOWER_X;
    case (cur_r.cmd)
      CMD_INIT: begin
        case (idx_r)
          4'd0:    cur_byte = LCD_FUNCTION_SET;
          4'd1:    cur_byte = LCD_DISPLAY_ON;
          4'd2:    cur_byte = LCD_ENTRY_MODE;
          4'd3:    cur_byte = LCD_CLEAR;
          default: cur_byte = LCD_HOME;
        endcase
      end
      CMD_CLIMATE: begin
        case (idx_r)
          4'd0:    cur_byte = ascii_digit(cur_r.dig[0]);
          4'd1:    cur_byte = ascii_digit(cur_r.dig[1]);
          4'd2:    cur_byte = CHR_PERCENT;
          4'd3:    cur_byte = CHR_SPACE;
          4'd4:    cur_byte = ascii_digit(cur_r.dig[2]);
          4'd5:    cur_byte = ascii_digit(cur_r.dig[3]);
          4'd6:    cur_byte = CHR_POINT;
          4'd7:    cur_byte = ascii_digit(cur_r.dig[4]);
          4'd8:    cur_byte = ascii_digit(cur_r.dig[5]);
          4'd9:    cur_byte = ascii_digit(cur_r.dig[6]);
          4'd10:   cur_byte = CHR_DEGREE;
          default: cur_byte = CHR_UPPER_C;
        endcase
      end
      default: begin
        case (idx_r)
          4'd0:    cur_byte = ascii_digit(cur_r.dig[0]);
          4'd1:    cur_byte = ascii_digit(cur_r.dig[1]);
          4'd2:    cur_byte = ascii_digit(cur_r.dig[2]);
          4'd3:    cur_byte = ascii_digit(cur_r.dig[3]);
          4'd4:    cur_byte = ascii_digit(cur_r.dig[4]);
          4'd5:    cur_byte = CHR_UPPER_L;
          default: cur_byte = CHR_LOWER_X;
        endcase
      end
    endcase
  end

  always_comb begin
    cur_nxt       = cur_r;
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + 4'd1;
      if (at_last) begin
        active_nxt = 1'b0;
      end
    end
    if (job_valid && job_ready) begin
      cur_nxt    = job;
      active_nxt = 1'b1;
      idx_nxt    = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r <= cur_nxt;
    if (emit) begin
      rs_r   <= (cur_r.cmd != CMD_INIT);
      byte_r <= cur_byte;
      last_r <= at_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_register_select = rs_r;
  assign out_lcd_byte        = byte_r;
  assign out_last            = last_r;

endmodule

[hw/rtl/lcd_reading_formatter_core.sv]
// lcd_reading_formatter_core: turns display requests into runs of display bus writes
//
// input channel: one request per beat (command plus the readings); the command
// selects the init run (five command bytes), the climate run (twelve data bytes)
// or the light run (seven data bytes); the unused command code is taken and dropped
// output channel: one display write per beat, register select, byte and a last
// flag on the final write of each run
// conversion: a light request first goes through its decimal conversion (two bits
// a cycle through the binary to decimal shifter); init and climate requests go
// straight to the queue
// throughput: the back end sends one write per cycle while the receiver is ready;
// a queue of QUEUE_DEPTH jobs lets the front accept and convert the next requests
// while a run is going out; the front takes no new request while a light conversion
// runs or while its result still waits for the queue
// reset: clears the queue, the converter and the output valid register, no clearing pass
// stall: when the receiver drops ready the output holds, the back end waits, the
// queue fills and then in_ready goes low
module lcd_reading_formatter_core #(
  parameter int QUEUE_DEPTH = lrf_pkg::LRF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_humidity,
  input  logic [7:0]  in_temp_whole,
  input  logic [7:0]  in_temp_fraction,
  input  logic [15:0] in_light_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_register_select,
  output logic [7:0]  out_lcd_byte,
  output logic        out_last
);
  import lrf_pkg::*;

  logic     push_valid, push_ready, pop_valid, pop_ready;
  lrf_job_t push_job, pop_job;

  lrf_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_humidity      (in_humidity),
    .in_temp_whole    (in_temp_whole),
    .in_temp_fraction (in_temp_fraction),
    .in_light_level   (in_light_level),
    .job_valid        (push_valid),
    .job_ready        (push_ready),
    .job              (push_job)
  );

  lrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  lrf_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .job_valid           (pop_valid),
    .job_ready           (pop_ready),
    .job                 (pop_job),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_register_select (out_register_select),
    .out_lcd_byte        (out_lcd_byte),
    .out_last            (out_last)
  );

endmodule
